FILE: rtl/frd_pkg.sv
// Shared types and constants for the framebuffer rectangle draw engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package frd_pkg;

  // Field widths of the command and result words
  localparam int KIND_W  = 3;
  localparam int XIN_W   = 9;
  localparam int YIN_W   = 8;
  localparam int COLOR_W = 8;

  // Internal coordinates cover screens up to 1024 pixels on a side
  localparam int COORD_W = 10;
  localparam int LIMIT_W = COORD_W + 1;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_SET     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_GET     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OUTLINE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FILLED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WIPE    = 3'd4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;

  // One queued job: a pixel read, or a rectangle walk of writes
  typedef struct packed {
    logic   rd;
    logic   outline;
    coord_t lo_x;
    coord_t hi_x;
    coord_t end_x;
    coord_t lo_y;
    coord_t hi_y;
    coord_t end_y;
    color_t color;
  } cmd_t;

  // One pixel access handed from the walker to the frame store
  typedef struct packed {
    logic   valid;
    logic   wr;
    coord_t x;
    coord_t y;
    color_t color;
  } pix_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

`default_nettype wire

FILE: rtl/frd_front.sv
// Command front end: sorts and clamps box corners, drops dead commands.
// Depends on frd_pkg.
`default_nettype none

module frd_front import frd_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic [KIND_W-1:0]  kind,
  input  logic [XIN_W-1:0]   x_first,
  input  logic [YIN_W-1:0]   y_first,
  input  logic [XIN_W-1:0]   x_second,
  input  logic [YIN_W-1:0]   y_second,
  input  logic [COLOR_W-1:0] color,
  input  logic               accept,
  output logic               push,
  output cmd_t               entry
);

  coord_t xa, ya, xb, yb;
  coord_t lo_x, hi_x, lo_y, hi_y, end_x, end_y;
  logic   off_screen;
  logic   keep;

  always_comb begin
    xa = COORD_W'(x_first);
    ya = COORD_W'(y_first);
    xb = COORD_W'(x_second);
    yb = COORD_W'(y_second);
    lo_x = (xa < xb) ? xa : xb;
    hi_x = (xa < xb) ? xb : xa;
    lo_y = (ya < yb) ? ya : yb;
    hi_y = (ya < yb) ? yb : ya;
    end_x = ({1'b0, hi_x} >= LIMIT_W'(SCREEN_WIDTH))  ? COORD_W'(SCREEN_WIDTH - 1)  : hi_x;
    end_y = ({1'b0, hi_y} >= LIMIT_W'(SCREEN_HEIGHT)) ? COORD_W'(SCREEN_HEIGHT - 1) : hi_y;
    off_screen = ({1'b0, lo_x} >= LIMIT_W'(SCREEN_WIDTH)) ||
                 ({1'b0, lo_y} >= LIMIT_W'(SCREEN_HEIGHT));

    // single pixel by default; off-screen pixels are clipped downstream
    keep          = 1'b0;
    entry.rd      = 1'b0;
    entry.outline = 1'b0;
    entry.lo_x    = xa;
    entry.hi_x    = xa;
    entry.end_x   = xa;
    entry.lo_y    = ya;
    entry.hi_y    = ya;
    entry.end_y   = ya;
    entry.color   = color;

    unique case (kind)
      KIND_SET: begin
        keep = 1'b1;
      end
      KIND_GET: begin
        keep     = 1'b1;
        entry.rd = 1'b1;
      end
      KIND_OUTLINE, KIND_FILLED: begin
        keep          = !off_screen;
        entry.outline = (kind == KIND_OUTLINE);
        entry.lo_x    = lo_x;
        entry.hi_x    = hi_x;
        entry.end_x   = end_x;
        entry.lo_y    = lo_y;
        entry.hi_y    = hi_y;
        entry.end_y   = end_y;
      end
      KIND_WIPE: begin
        keep        = 1'b1;
        entry.lo_x  = '0;
        entry.hi_x  = COORD_W'(SCREEN_WIDTH - 1);
        entry.end_x = COORD_W'(SCREEN_WIDTH - 1);
        entry.lo_y  = '0;
        entry.hi_y  = COORD_W'(SCREEN_HEIGHT - 1);
        entry.end_y = COORD_W'(SCREEN_HEIGHT - 1);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

`default_nettype wire

FILE: rtl/frd_queue.sv
// Short command queue between the front end and the rectangle walker.
// Depends on frd_pkg.
`default_nettype none

module frd_queue import frd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_entry,
  input  logic   pop,
  output cmd_t   head,
  output qstat_t stat
);

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (Q_PTR_W + 1)'(Q_DEPTH));

endmodule

`default_nettype wire

FILE: rtl/frd_back.sv
// Rectangle walker: turns one queued job into one pixel access per cycle.
// Depends on frd_pkg.
`default_nettype none

module frd_back import frd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   head,
  input  qstat_t stat,
  output logic   pop,
  output pix_t   pix
);

  logic   active;
  cmd_t   cur;
  coord_t x;
  coord_t y;

  logic   full_row;
  logic   row_last;
  logic   last;
  coord_t x_next;
  coord_t y_next;
  pix_t   pix_next;

  always_comb begin
    // outline middle rows visit only the left and right columns
    full_row = !cur.outline || (y == cur.lo_y) || (y == cur.hi_y);
    row_last = full_row ? (x == cur.end_x) : (x == cur.hi_x);
    last     = row_last && (y == cur.end_y);
    if (row_last) begin
      x_next = cur.lo_x;
      y_next = y + 1'b1;
    end else begin
      x_next = full_row ? x + 1'b1 : cur.hi_x;
      y_next = y;
    end
    pop = !stat.empty && (!active || last);

    pix_next.valid = active;
    pix_next.wr    = !cur.rd;
    pix_next.x     = x;
    pix_next.y     = y;
    pix_next.color = cur.color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pix.valid <= 1'b0;
    end else begin
      pix.valid <= pix_next.valid;
      if (pop) begin
        active <= 1'b1;
      end else if (last) begin
        active <= 1'b0;
      end
    end
    pix.wr    <= pix_next.wr;
    pix.x     <= pix_next.x;
    pix.y     <= pix_next.y;
    pix.color <= pix_next.color;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
      x   <= head.lo_x;
      y   <= head.lo_y;
    end else if (active) begin
      x <= x_next;
      y <= y_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/frd_store.sv
// Frame store: clips, forms the pixel address, and reads or writes the memory.
// Depends on frd_pkg.
`default_nettype none

module frd_store import frd_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic         clk,
  input  logic         rst,
  input  pix_t         pix,
  output logic         read_strobe,
  output logic [COLOR_W-1:0] read_color
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic            on_screen;
  logic [AW-1:0]   addr_calc;

  logic            s1_wr;
  logic            s1_rd;
  logic            s1_in;
  logic [AW-1:0]   s1_addr;
  color_t          s1_color;

  color_t          mem [DEPTH];
  color_t          rdata;
  logic            rd_valid;
  logic            rd_in;

  assign on_screen = ({1'b0, pix.x} < LIMIT_W'(SCREEN_WIDTH)) &&
                     ({1'b0, pix.y} < LIMIT_W'(SCREEN_HEIGHT));
  assign addr_calc = AW'(pix.x) + AW'(pix.y) * AW'(SCREEN_WIDTH);

  // address stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_wr <= 1'b0;
      s1_rd <= 1'b0;
    end else begin
      s1_wr <= pix.valid && pix.wr && on_screen;
      s1_rd <= pix.valid && !pix.wr;
    end
  end

  always_ff @(posedge clk) begin
    s1_in    <= on_screen;
    s1_addr  <= addr_calc;
    s1_color <= pix.color;
  end

  // memory stage
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_addr] <= s1_color;
    end
    if (s1_rd && s1_in) begin
      rdata <= mem[s1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= s1_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_in <= s1_in;
  end

  // off-screen reads answer zero
  assign read_strobe = rd_valid;
  assign read_color  = rd_in ? rdata : '0;

endmodule

`default_nettype wire

FILE: rtl/framebuffer_rectangle_draw.sv
// Framebuffer rectangle draw engine: one byte per pixel, SCREEN_WIDTH by
// SCREEN_HEIGHT pixels, addressed as x + y * SCREEN_WIDTH. A command is taken
// when start is high and busy is low; busy rises only when the four-entry
// command queue is full. The walker issues one pixel access per cycle: one
// for a set or get pixel, one per edge pixel visited for an outline box, one
// per clipped-rectangle pixel for a filled box, and every pixel for a wipe.
// The walker, with its single memory port, sets that rate. A get pixel result
// appears on read_strobe and read_color for one cycle, three cycles after
// the walker reaches it, and must be taken then: there is no hold-off. Reads
// of pixels never written since reset return undefined data; off-screen reads
// return zero, and off-screen writes are dropped.
// Depends on frd_pkg, frd_front, frd_queue, frd_back, frd_store.
`default_nettype none

module framebuffer_rectangle_draw import frd_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [KIND_W-1:0]  kind,
  input  logic [XIN_W-1:0]   x_first,
  input  logic [YIN_W-1:0]   y_first,
  input  logic [XIN_W-1:0]   x_second,
  input  logic [YIN_W-1:0]   y_second,
  input  logic [COLOR_W-1:0] color,
  output logic               read_strobe,
  output logic [COLOR_W-1:0] read_color
);

  logic   accept;
  logic   push;
  cmd_t   entry;
  cmd_t   head;
  qstat_t qs;
  logic   pop;
  pix_t   pix;

  assign busy   = qs.full;
  assign accept = start && !busy;

  frd_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .kind     (kind),
    .x_first  (x_first),
    .y_first  (y_first),
    .x_second (x_second),
    .y_second (y_second),
    .color    (color),
    .accept   (accept),
    .push     (push),
    .entry    (entry)
  );

  frd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .stat       (qs)
  );

  frd_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .stat (qs),
    .pop  (pop),
    .pix  (pix)
  );

  frd_store #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .pix         (pix),
    .read_strobe (read_strobe),
    .read_color  (read_color)
  );

  // a result only ever follows a pixel read out of the walker
  a_strobe_from_read: assert property (@(posedge clk) disable iff (rst)
    read_strobe |-> $past(pix.valid && !pix.wr, 2))
    else $error("result strobe without a pixel read");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    push |=> !qs.empty)
    else $error("queue empty after a push");

  a_fill_needs_push: assert property (@(posedge clk) disable iff (rst)
    $fell(qs.empty) |-> $past(push))
    else $error("queue gained an entry without a push");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for framebuffer_rectangle_draw: directed and random
// drawing commands are checked against a pixel-level copy of the frame store.
// Depends on rtl/frd_pkg.sv and the block's RTL; reads no files.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frd_pkg::*;

  localparam int SCR_W       = 320;
  localparam int SCR_H       = 200;
  localparam int SCR_PIXELS  = SCR_W * SCR_H;
  localparam int X_SPAN      = 1 << XIN_W;
  localparam int Y_SPAN      = 1 << YIN_W;
  localparam int RANDOM_CMDS = 1525;
  localparam int SPOT_KEEP   = 16;
  // Slowest run: a handful of wipes and full-screen boxes of 64000 pixels each,
  // hundreds of small boxes and sender gaps; take it several times over.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 64;

  // Kinds past wipe are ignored by the block
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_WIPE + 3'd1;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    int     x;
    int     y;
    color_t color;
  } pixel_read_t;

  typedef struct {
    int x;
    int y;
  } spot_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [KIND_W-1:0]  kind;
  logic [XIN_W-1:0]   x_first;
  logic [YIN_W-1:0]   y_first;
  logic [XIN_W-1:0]   x_second;
  logic [YIN_W-1:0]   y_second;
  logic [COLOR_W-1:0] color;
  logic               read_strobe;
  logic [COLOR_W-1:0] read_color;

  color_t      frame_copy [SCR_PIXELS];
  bit          pixel_written [SCR_PIXELS];
  pixel_read_t reads_pending [$];
  spot_t       recent_spots [$];

  int fail_count    = 0;
  int cmds_sent     = 0;
  int reads_checked = 0;
  int cycle_count   = 0;
  int idle_pct      = 0;

  framebuffer_rectangle_draw #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .x_first    (x_first),
    .y_first    (y_first),
    .x_second   (x_second),
    .y_second   (y_second),
    .color      (color),
    .read_strobe(read_strobe),
    .read_color (read_color)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------- frame store prediction ----------------

  function automatic void paint_pixel(int x, int y, color_t c);
    if (x >= SCR_W || y >= SCR_H) return;
    frame_copy[x + y * SCR_W]    = c;
    pixel_written[x + y * SCR_W] = 1'b1;
  endfunction

  function automatic color_t peek_pixel(int x, int y);
    if (x >= SCR_W || y >= SCR_H) return '0;
    return frame_copy[x + y * SCR_W];
  endfunction

  function automatic void draw_rect(int xa, int ya, int xb, int yb, color_t c, bit filled);
    int lo_x, hi_x, lo_y, hi_y, end_x, end_y;
    lo_x = (xa < xb) ? xa : xb;
    hi_x = (xa < xb) ? xb : xa;
    lo_y = (ya < yb) ? ya : yb;
    hi_y = (ya < yb) ? yb : ya;
    if (lo_x >= SCR_W || lo_y >= SCR_H) return;
    end_x = (hi_x >= SCR_W) ? SCR_W - 1 : hi_x;
    end_y = (hi_y >= SCR_H) ? SCR_H - 1 : hi_y;
    if (filled) begin
      for (int y = lo_y; y <= end_y; y++)
        for (int x = lo_x; x <= end_x; x++)
          paint_pixel(x, y, c);
    end else begin
      // An off-screen far edge is dropped pixel by pixel, not pulled in
      for (int y = lo_y; y <= end_y; y++) begin
        paint_pixel(lo_x, y, c);
        paint_pixel(hi_x, y, c);
      end
      for (int x = lo_x; x <= end_x; x++) begin
        paint_pixel(x, lo_y, c);
        paint_pixel(x, hi_y, c);
      end
    end
  endfunction

  function automatic void apply_command(logic [KIND_W-1:0] k, int xa, int ya, int xb, int yb,
                                        color_t c);
    pixel_read_t rd;
    case (k)
      KIND_SET:     paint_pixel(xa, ya, c);
      KIND_GET: begin
        rd.x     = xa;
        rd.y     = ya;
        rd.color = peek_pixel(xa, ya);
        reads_pending.push_back(rd);
      end
      KIND_OUTLINE: draw_rect(xa, ya, xb, yb, c, 1'b0);
      KIND_FILLED:  draw_rect(xa, ya, xb, yb, c, 1'b1);
      KIND_WIPE: begin
        foreach (frame_copy[i]) begin
          frame_copy[i]    = c;
          pixel_written[i] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------- command side ----------------

  task automatic send_word(input logic [KIND_W-1:0] k, input logic [XIN_W-1:0] xa,
                           input logic [YIN_W-1:0] ya, input logic [XIN_W-1:0] xb,
                           input logic [YIN_W-1:0] yb, input color_t c);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    kind     <= k;
    x_first  <= xa;
    y_first  <= ya;
    x_second <= xb;
    y_second <= yb;
    color    <= c;
    // Sample busy mid-cycle; the word goes in at the next rising edge if low
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    apply_command(k, int'(xa), int'(ya), int'(xb), int'(yb), c);
    cmds_sent++;
  endtask

  task automatic wait_for_reads();
    start <= 1'b0;
    while (reads_pending.size() != 0) @(posedge clk);
  endtask

  // ---------------- result side ----------------

  always @(negedge clk) begin
    pixel_read_t want;
    if (!rst && read_strobe !== 1'b0) begin
      if (reads_pending.size() == 0) begin
        $error("read_color %0h arrived with no pixel read pending", read_color);
        fail_count++;
      end else begin
        want = reads_pending.pop_front();
        reads_checked++;
        if (read_color !== want.color) begin
          $error("read_color at (%0d,%0d): expected %0h, actual %0h",
                 want.x, want.y, want.color, read_color);
          fail_count++;
        end
      end
    end
  end

  // ---------------- directed tests ----------------

  task automatic test_set_get_pixel();
    send_word(KIND_SET, 9'd0, 8'd0, 9'd0, 8'd0, 8'hFF);
    send_word(KIND_SET, 9'd319, 8'd199, 9'd0, 8'd0, 8'h00);
    send_word(KIND_SET, 9'd5, 8'd7, 9'd511, 8'd255, 8'hA5);
    send_word(KIND_GET, 9'd0, 8'd0, 9'd0, 8'd0, 8'h00);
    send_word(KIND_GET, 9'd319, 8'd199, 9'd0, 8'd0, 8'hFF);
    send_word(KIND_GET, 9'd5, 8'd7, 9'd0, 8'd0, 8'h00);
  endtask

  task automatic test_outline_box();
    // Corners given high first; edges must still land
    send_word(KIND_OUTLINE, 9'd310, 8'd190, 9'd300, 8'd180, 8'h3C);
    send_word(KIND_GET, 9'd300, 8'd185, 9'd0, 8'd0, 8'h00);
    send_word(KIND_GET, 9'd305, 8'd180, 9'd0, 8'd0, 8'h00);
  endtask

  task automatic test_filled_box();
    send_word(KIND_FILLED, 9'd10, 8'd20, 9'd4, 8'd12, 8'hC3);
    send_word(KIND_GET, 9'd7, 8'd15, 9'd0, 8'd0, 8'h00);
    send_word(KIND_FILLED, 9'd50, 8'd50, 9'd50, 8'd50, 8'h01);
    send_word(KIND_GET, 9'd50, 8'd50, 9'd0, 8'd0, 8'h00);
  endtask

  task automatic test_off_screen();
    send_word(KIND_SET, 9'd511, 8'd255, 9'd0, 8'd0, 8'hEE);
    send_word(KIND_GET, 9'd511, 8'd255, 9'd0, 8'd0, 8'h00);
    send_word(KIND_GET, 9'd320, 8'd0, 9'd0, 8'd0, 8'h00);
    send_word(KIND_GET, 9'd0, 8'd200, 9'd0, 8'd0, 8'h00);
    // Far corner off screen: box clipped to the right and bottom
    send_word(KIND_OUTLINE, 9'd315, 8'd195, 9'd400, 8'd230, 8'h77);
    send_word(KIND_GET, 9'd315, 8'd199, 9'd0, 8'd0, 8'h00);
    send_word(KIND_GET, 9'd319, 8'd195, 9'd0, 8'd0, 8'h00);
    // Near corner off screen: nothing drawn
    send_word(KIND_FILLED, 9'd330, 8'd10, 9'd340, 8'd20, 8'h99);
  endtask

  task automatic test_spare_kinds();
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      send_word(k[KIND_W-1:0], 9'd0, 8'd0, 9'd319, 8'd199, 8'h11);
    send_word(KIND_GET, 9'd0, 8'd0, 9'd0, 8'd0, 8'h00);
  endtask

  task automatic test_wipe();
    send_word(KIND_WIPE, 9'd0, 8'd0, 9'd0, 8'd0, 8'h5A);
    send_word(KIND_GET, 9'd160, 8'd100, 9'd0, 8'd0, 8'h00);
    send_word(KIND_OUTLINE, 9'd511, 8'd255, 9'd0, 8'd0, 8'h80);
    send_word(KIND_GET, 9'd0, 8'd100, 9'd0, 8'd0, 8'h00);
    send_word(KIND_GET, 9'd160, 8'd100, 9'd0, 8'd0, 8'h00);
  endtask

  // ---------------- random traffic ----------------

  function automatic int rand_col();
    return ($urandom_range(9) == 0) ? $urandom_range(X_SPAN - 1, SCR_W) : $urandom_range(SCR_W - 1);
  endfunction

  function automatic int rand_row();
    return ($urandom_range(9) == 0) ? $urandom_range(Y_SPAN - 1, SCR_H) : $urandom_range(SCR_H - 1);
  endfunction

  function automatic int near(int v, int span);
    int r;
    r = v + int'($urandom_range(30)) - 15;
    if (r < 0) r = 0;
    if (r > span - 1) r = span - 1;
    return r;
  endfunction

  task automatic test_random_traffic(input int pct, input int count);
    int sent, pick, xa, ya, xb, yb, r;
    logic [KIND_W-1:0] k;
    spot_t s;
    idle_pct = pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(999);
      xa = rand_col();
      ya = rand_row();
      xb = near(xa, X_SPAN);
      yb = near(ya, Y_SPAN);
      if (pick < 300)      k = KIND_SET;
      else if (pick < 650) k = KIND_GET;
      else if (pick < 780) k = KIND_OUTLINE;
      else if (pick < 960) k = KIND_FILLED;
      else if (pick < 962) k = KIND_WIPE;
      else                 k = KIND_SPARE_LO +
                               KIND_W'($urandom_range(KIND_SPARE_HI - KIND_SPARE_LO));

      if (k == KIND_GET) begin
        // Aim most reads at recently drawn pixels
        r = $urandom_range(9);
        if (r < 6 && recent_spots.size() != 0) begin
          s  = recent_spots[$urandom_range(recent_spots.size() - 1)];
          xa = s.x;
          ya = s.y;
        end else if (r < 9) begin
          xa = $urandom_range(SCR_W - 1);
          ya = $urandom_range(SCR_H - 1);
        end else begin
          xa = $urandom_range(X_SPAN - 1, SCR_W);
          ya = $urandom_range(Y_SPAN - 1);
        end
        // Never read an on-screen pixel that nothing has written yet
        if (xa < SCR_W && ya < SCR_H && !pixel_written[xa + ya * SCR_W]) k = KIND_SET;
      end

      if ((k == KIND_OUTLINE || k == KIND_FILLED) && $urandom_range(127) == 0) begin
        xb = $urandom_range(X_SPAN - 1);
        yb = $urandom_range(Y_SPAN - 1);
      end

      if (k == KIND_SET || k == KIND_OUTLINE || k == KIND_FILLED) begin
        s.x = xa;
        s.y = ya;
        recent_spots.push_back(s);
        if (recent_spots.size() > SPOT_KEEP) void'(recent_spots.pop_front());
      end

      send_word(k, xa[XIN_W-1:0], ya[YIN_W-1:0], xb[XIN_W-1:0], yb[YIN_W-1:0],
                color_t'($urandom_range(255)));
      if (k <= KIND_WIPE) sent++;
    end
  endtask

  // ---------------- sequence ----------------

  initial begin
    rst      <= 1'b1;
    start    <= 1'b0;
    kind     <= KIND_SET;
    x_first  <= '0;
    y_first  <= '0;
    x_second <= '0;
    y_second <= '0;
    color    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_set_get_pixel();
    test_outline_box();
    test_filled_box();
    test_off_screen();
    test_spare_kinds();
    test_wipe();

    test_random_traffic(37, RANDOM_CMDS / 3);
    wait_for_reads();
    test_random_traffic(59, RANDOM_CMDS / 3);
    wait_for_reads();
    test_random_traffic(0, RANDOM_CMDS - 2 * (RANDOM_CMDS / 3));

    wait_for_reads();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d commands sent, %0d pixel reads checked", cmds_sent, reads_checked);
    $display("tb: covered pixels, outline and filled boxes, clipping, wipes, spare kinds");
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
